// ===== hw/rtl/etpc_pkg.sv =====
package etpc_pkg;

  localparam int Palettes  = 4;
  localparam int Entries   = 16;
  localparam int CountBits = 16;

  localparam int IterW    = 16;
  localparam int DenW     = 16;
  localparam int CcW      = 5;
  localparam int ChanW    = 8;
  localparam int Chans    = 3;
  localparam int ColorW   = 24;
  localparam int PalSelW  = 2;
  localparam int PalNumW  = 2;
  localparam int EntIdxW  = 4;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  // counts are taken modulo 2^CountBits
  localparam logic [IterW-1:0] CountMask = (CountBits >= IterW) ? {IterW{1'b1}} :
                                           IterW'((64'(1) << CountBits) - 64'(1));

  localparam logic [DenW-1:0]    ResetMaxIter  = 16'd256;
  localparam logic [DenW-1:0]    ResetCycle    = 16'd0;
  localparam logic [CcW-1:0]     ResetColors   = 5'd2;
  localparam logic [PalSelW-1:0] ResetPalette  = 2'd0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_ITER = 2'd0,
    CFG_CYCLE    = 2'd1,
    CFG_COLORS   = 2'd2,
    CFG_PALETTE  = 2'd3
  } cfg_index_t;

  typedef enum logic {
    OP_COLOR = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef struct packed {
    logic               operation;
    logic [IterW-1:0]   iteration;
    logic [PalNumW-1:0] palette_number;
    logic [EntIdxW-1:0] entry_index;
    logic [ColorW-1:0]  entry_color;
  } request_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             escaped_limit;
  } result_t;

  typedef struct packed {
    logic [DenW-1:0]    max_iterations;
    logic [DenW-1:0]    cycle_length;
    logic [CcW-1:0]     color_count;
    logic [PalSelW-1:0] palette_select;
  } cfg_t;

  // one classified request as it travels from front to back
  typedef struct packed {
    logic               is_write;
    logic               wr_en;
    logic               limit;
    logic [IterW-1:0]   count;
    logic [DenW-1:0]    den;
    logic [CcW-1:0]     segs;
    logic [PalNumW-1:0] palette_number;
    logic [EntIdxW-1:0] entry_index;
    logic [ColorW-1:0]  entry_color;
  } item_t;

endpackage

// ===== hw/rtl/etpc_front.sv =====
module etpc_front #(
  parameter int PALETTES = etpc_pkg::Palettes,
  parameter int ENTRIES  = etpc_pkg::Entries
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  etpc_pkg::request_t request,
  input  etpc_pkg::cfg_t     cfg,
  input  logic               q_full,
  output logic               busy,
  output logic               push,
  output etpc_pkg::item_t    item
);

  logic            f_v;
  etpc_pkg::item_t f_item;
  etpc_pkg::item_t f_item_next;

  assign busy = f_v && q_full;
  assign push = f_v && !q_full;
  assign item = f_item;

  always_comb begin
    logic [etpc_pkg::IterW-1:0] count;
    logic [etpc_pkg::CcW-1:0]   cc;
    count = request.iteration & etpc_pkg::CountMask;
    cc = cfg.color_count;
    if (cc < etpc_pkg::CcW'(2)) cc = etpc_pkg::CcW'(2);
    if (int'(cc) > ENTRIES) cc = etpc_pkg::CcW'(ENTRIES);

    f_item_next.is_write = (request.operation == etpc_pkg::OP_WRITE);
    f_item_next.wr_en = (request.operation == etpc_pkg::OP_WRITE) &&
                        (int'(request.palette_number) < PALETTES) &&
                        (int'(request.entry_index) < ENTRIES);
    f_item_next.limit = (count >= cfg.max_iterations);
    f_item_next.count = count;
    // cycling off uses the limit as denominator; then count < den and the modulo is a no-op
    if (cfg.cycle_length >= etpc_pkg::DenW'(2)) begin
      f_item_next.den = cfg.cycle_length - etpc_pkg::DenW'(1);
    end else begin
      f_item_next.den = cfg.max_iterations;
    end
    f_item_next.segs = cc - etpc_pkg::CcW'(1);
    f_item_next.palette_number = request.palette_number;
    f_item_next.entry_index = request.entry_index;
    f_item_next.entry_color = request.entry_color;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (!busy) begin
      f_v <= start;
    end
    if (!busy) begin
      f_item <= f_item_next;
    end
  end

endmodule

// ===== hw/rtl/etpc_queue.sv =====
module etpc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  etpc_pkg::item_t push_item,
  input  logic            pop,
  output logic            valid,
  output logic            full,
  output etpc_pkg::item_t head
);

  localparam int Depth = 2;

  etpc_pkg::item_t slots [Depth];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      fill;

  assign valid = (fill != 2'd0);
  assign full  = (fill == 2'(Depth));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== hw/rtl/etpc_back.sv =====
module etpc_back #(
  parameter int PALETTES = etpc_pkg::Palettes,
  parameter int ENTRIES  = etpc_pkg::Entries
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  etpc_pkg::item_t                q_item,
  output logic                           pop,
  input  logic [etpc_pkg::PalSelW-1:0]   palette_select,
  output logic                           done,
  output etpc_pkg::result_t              result
);

  localparam int DenW     = etpc_pkg::DenW;
  localparam int CcW      = etpc_pkg::CcW;
  localparam int ChanW    = etpc_pkg::ChanW;
  localparam int Chans    = etpc_pkg::Chans;
  localparam int ColorW   = etpc_pkg::ColorW;
  localparam int ModSteps = etpc_pkg::IterW;
  localparam int KSteps   = CcW;
  localparam int ChSteps  = ChanW;
  localparam int ScaledW  = DenW + CcW;
  localparam int SumW     = DenW + ChanW;
  localparam int Depth    = PALETTES * ENTRIES;
  localparam int AddrW    = (Depth > 1) ? $clog2(Depth) : 1;

  // the back never holds off the queue
  assign pop = q_valid;

  // count mod den, one quotient bit per stage
  logic            mi_v     [ModSteps];
  etpc_pkg::item_t mi_item  [ModSteps];
  logic [DenW-1:0] mi_r     [ModSteps];
  logic            m_v      [ModSteps];
  etpc_pkg::item_t m_item   [ModSteps];
  logic [DenW-1:0] m_r      [ModSteps];
  logic [DenW-1:0] m_r_next [ModSteps];

  always_comb begin
    mi_v[0] = q_valid;
    mi_item[0] = q_item;
    mi_r[0] = '0;
    for (int s = 1; s < ModSteps; s++) begin
      mi_v[s] = m_v[s-1];
      mi_item[s] = m_item[s-1];
      mi_r[s] = m_r[s-1];
    end
  end

  always_comb begin
    logic [DenW:0] t;
    t = '0;
    for (int s = 0; s < ModSteps; s++) begin
      t = {mi_r[s], mi_item[s].count[ModSteps-1-s]};
      if (t >= {1'b0, mi_item[s].den}) begin
        m_r_next[s] = DenW'(t - {1'b0, mi_item[s].den});
      end else begin
        m_r_next[s] = t[DenW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < ModSteps; s++) begin
      if (rst) begin
        m_v[s] <= 1'b0;
      end else begin
        m_v[s] <= mi_v[s];
      end
      m_item[s] <= mi_item[s];
      m_r[s] <= m_r_next[s];
    end
  end

  // num * segs
  logic               sc_v;
  etpc_pkg::item_t    sc_item;
  logic [ScaledW-1:0] sc_scaled;

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_v <= 1'b0;
    end else begin
      sc_v <= m_v[ModSteps-1];
    end
    sc_item <= m_item[ModSteps-1];
    sc_scaled <= ScaledW'(m_r[ModSteps-1]) * ScaledW'(m_item[ModSteps-1].segs);
  end

  // segment index and weight: scaled / den; top bits start below den
  logic               ki_v    [KSteps];
  etpc_pkg::item_t    ki_item [KSteps];
  logic [DenW-1:0]    ki_r    [KSteps];
  logic [CcW-1:0]     ki_q    [KSteps];
  logic [ScaledW-1:0] ki_s    [KSteps];
  logic               k_v     [KSteps];
  etpc_pkg::item_t    k_item  [KSteps];
  logic [DenW-1:0]    k_r     [KSteps];
  logic [CcW-1:0]     k_q     [KSteps];
  logic [ScaledW-1:0] k_s     [KSteps];
  logic [DenW-1:0]    k_r_next [KSteps];
  logic [CcW-1:0]     k_q_next [KSteps];

  always_comb begin
    ki_v[0] = sc_v;
    ki_item[0] = sc_item;
    ki_r[0] = sc_scaled[ScaledW-1:CcW];
    ki_q[0] = '0;
    ki_s[0] = sc_scaled;
    for (int j = 1; j < KSteps; j++) begin
      ki_v[j] = k_v[j-1];
      ki_item[j] = k_item[j-1];
      ki_r[j] = k_r[j-1];
      ki_q[j] = k_q[j-1];
      ki_s[j] = k_s[j-1];
    end
  end

  always_comb begin
    logic [DenW:0] t;
    logic          ge;
    t = '0;
    ge = 1'b0;
    for (int j = 0; j < KSteps; j++) begin
      t = {ki_r[j], ki_s[j][CcW-1-j]};
      ge = (t >= {1'b0, ki_item[j].den});
      if (ge) begin
        k_r_next[j] = DenW'(t - {1'b0, ki_item[j].den});
      end else begin
        k_r_next[j] = t[DenW-1:0];
      end
      k_q_next[j] = {ki_q[j][CcW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < KSteps; j++) begin
      if (rst) begin
        k_v[j] <= 1'b0;
      end else begin
        k_v[j] <= ki_v[j];
      end
      k_item[j] <= ki_item[j];
      k_r[j] <= k_r_next[j];
      k_q[j] <= k_q_next[j];
      k_s[j] <= ki_s[j];
    end
  end

  // palette memory: writes travel in order with pixels, applied at the read stage
  logic [ColorW-1:0] pal_mem [Depth];
  logic [AddrW-1:0]  wr_addr;
  logic [AddrW-1:0]  lo_addr;
  logic [AddrW-1:0]  hi_addr;
  logic              mem_v;
  etpc_pkg::item_t   mem_item;
  logic [DenW-1:0]   mem_rem;
  logic [ColorW-1:0] rd_lo;
  logic [ColorW-1:0] rd_hi;

  assign wr_addr = AddrW'(int'(k_item[KSteps-1].palette_number) * ENTRIES +
                          int'(k_item[KSteps-1].entry_index));
  assign lo_addr = AddrW'(int'(palette_select) * ENTRIES + int'(k_q[KSteps-1]));
  assign hi_addr = lo_addr + AddrW'(1);

  always_ff @(posedge clk) begin
    if (k_v[KSteps-1] && k_item[KSteps-1].wr_en) begin
      pal_mem[wr_addr] <= k_item[KSteps-1].entry_color;
    end
    rd_lo <= pal_mem[lo_addr];
    rd_hi <= pal_mem[hi_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_v <= 1'b0;
    end else begin
      mem_v <= k_v[KSteps-1];
    end
    mem_item <= k_item[KSteps-1];
    mem_rem <= k_r[KSteps-1];
  end

  // blend weights: rem * hi and (den - rem) * lo per channel
  logic            p_v;
  etpc_pkg::item_t p_item;
  logic [SumW-1:0] p_hi [Chans];
  logic [SumW-1:0] p_lo [Chans];

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else begin
      p_v <= mem_v;
    end
    p_item <= mem_item;
    for (int c = 0; c < Chans; c++) begin
      p_hi[c] <= SumW'(mem_rem) * SumW'(rd_hi[c*ChanW +: ChanW]);
      p_lo[c] <= SumW'(mem_item.den - mem_rem) * SumW'(rd_lo[c*ChanW +: ChanW]);
    end
  end

  logic            s_v;
  etpc_pkg::item_t s_item;
  logic [SumW-1:0] s_sum [Chans];

  always_ff @(posedge clk) begin
    if (rst) begin
      s_v <= 1'b0;
    end else begin
      s_v <= p_v;
    end
    s_item <= p_item;
    for (int c = 0; c < Chans; c++) begin
      s_sum[c] <= p_hi[c] + p_lo[c];
    end
  end

  // channel = sum / den, one bit per stage; sum < 256 * den
  logic             ci_v    [ChSteps];
  etpc_pkg::item_t  ci_item [ChSteps];
  logic [DenW-1:0]  ci_r    [ChSteps][Chans];
  logic [ChanW-1:0] ci_q    [ChSteps][Chans];
  logic [SumW-1:0]  ci_s    [ChSteps][Chans];
  logic             c_v     [ChSteps];
  etpc_pkg::item_t  c_item  [ChSteps];
  logic [DenW-1:0]  c_r     [ChSteps][Chans];
  logic [ChanW-1:0] c_q     [ChSteps][Chans];
  logic [SumW-1:0]  c_s     [ChSteps][Chans];
  logic [DenW-1:0]  c_r_next [ChSteps][Chans];
  logic [ChanW-1:0] c_q_next [ChSteps][Chans];

  always_comb begin
    ci_v[0] = s_v;
    ci_item[0] = s_item;
    for (int c = 0; c < Chans; c++) begin
      ci_r[0][c] = s_sum[c][SumW-1:ChanW];
      ci_q[0][c] = '0;
      ci_s[0][c] = s_sum[c];
    end
    for (int j = 1; j < ChSteps; j++) begin
      ci_v[j] = c_v[j-1];
      ci_item[j] = c_item[j-1];
      for (int c = 0; c < Chans; c++) begin
        ci_r[j][c] = c_r[j-1][c];
        ci_q[j][c] = c_q[j-1][c];
        ci_s[j][c] = c_s[j-1][c];
      end
    end
  end

  always_comb begin
    logic [DenW:0] t;
    logic          ge;
    t = '0;
    ge = 1'b0;
    for (int j = 0; j < ChSteps; j++) begin
      for (int c = 0; c < Chans; c++) begin
        t = {ci_r[j][c], ci_s[j][c][ChanW-1-j]};
        ge = (t >= {1'b0, ci_item[j].den});
        if (ge) begin
          c_r_next[j][c] = DenW'(t - {1'b0, ci_item[j].den});
        end else begin
          c_r_next[j][c] = t[DenW-1:0];
        end
        c_q_next[j][c] = {ci_q[j][c][ChanW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < ChSteps; j++) begin
      if (rst) begin
        c_v[j] <= 1'b0;
      end else begin
        c_v[j] <= ci_v[j];
      end
      c_item[j] <= ci_item[j];
      for (int c = 0; c < Chans; c++) begin
        c_r[j][c] <= c_r_next[j][c];
        c_q[j][c] <= c_q_next[j][c];
        c_s[j][c] <= ci_s[j][c];
      end
    end
  end

  // write requests end here without a result
  assign done = c_v[ChSteps-1] && !c_item[ChSteps-1].is_write;

  always_comb begin
    if (c_item[ChSteps-1].limit) begin
      result.red = '0;
      result.green = '0;
      result.blue = '0;
      result.escaped_limit = 1'b1;
    end else begin
      result.red = c_q[ChSteps-1][2];
      result.green = c_q[ChSteps-1][1];
      result.blue = c_q[ChSteps-1][0];
      result.escaped_limit = 1'b0;
    end
  end

endmodule

// ===== hw/rtl/escape_time_palette_colorer.sv =====
// Escape-time palette colorer: maps a pixel's escape count to an RGB color.
// Request channel: a request is taken at a rising edge with start high and
// busy low. operation selects coloring a pixel or writing one palette entry.
// Result channel: done is high for one cycle with result valid; the receiver
// cannot stall, so the pipeline never waits on the output side.
// Throughput: one request per clock. busy only rises if the queue between the
// classifying front and the arithmetic back fills, which a full-rate back
// never lets happen.
// Pipeline: a pixel request passes through one front stage, one queue stage,
// a 16-stage modulo, a multiply, a 5-stage segment divide, the palette read,
// two blend stages and an 8-stage channel divide. A palette write gives no
// result.
// Configuration: cfg_we with cfg_index and cfg_data writes a register at once;
// write only while no request is in flight.
// Reset (rst, synchronous) restores the register defaults and empties the
// pipeline; palette contents are undefined until written.
module escape_time_palette_colorer #(
  parameter int PALETTES = etpc_pkg::Palettes,
  parameter int ENTRIES  = etpc_pkg::Entries
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  etpc_pkg::request_t            request,
  output logic                          done,
  output etpc_pkg::result_t             result,
  input  logic                          cfg_we,
  input  logic [etpc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [etpc_pkg::CfgDataW-1:0] cfg_data
);

  etpc_pkg::cfg_t                 cfg;
  logic [etpc_pkg::PalSelW-1:0]   pal_wrapped;
  logic                           q_full;
  logic                           q_valid;
  logic                           push;
  logic                           pop;
  etpc_pkg::item_t                front_item;
  etpc_pkg::item_t                q_head;

  // palette select wraps modulo the palette count
  always_comb begin
    pal_wrapped = cfg_data[etpc_pkg::PalSelW-1:0];
    for (int i = 0; i < (1 << etpc_pkg::PalSelW); i++) begin
      if (int'(pal_wrapped) >= PALETTES) begin
        pal_wrapped = pal_wrapped - etpc_pkg::PalSelW'(PALETTES);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_iterations <= etpc_pkg::ResetMaxIter;
      cfg.cycle_length <= etpc_pkg::ResetCycle;
      cfg.color_count <= etpc_pkg::ResetColors;
      cfg.palette_select <= etpc_pkg::ResetPalette;
    end else if (cfg_we) begin
      unique case (etpc_pkg::cfg_index_t'(cfg_index))
        etpc_pkg::CFG_MAX_ITER: cfg.max_iterations <= cfg_data;
        etpc_pkg::CFG_CYCLE:    cfg.cycle_length <= cfg_data;
        etpc_pkg::CFG_COLORS:   cfg.color_count <= cfg_data[etpc_pkg::CcW-1:0];
        etpc_pkg::CFG_PALETTE:  cfg.palette_select <= pal_wrapped;
        default: begin
        end
      endcase
    end
  end

  etpc_front #(
    .PALETTES(PALETTES),
    .ENTRIES (ENTRIES)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .request(request),
    .cfg    (cfg),
    .q_full (q_full),
    .busy   (busy),
    .push   (push),
    .item   (front_item)
  );

  etpc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(front_item),
    .pop      (pop),
    .valid    (q_valid),
    .full     (q_full),
    .head     (q_head)
  );

  etpc_back #(
    .PALETTES(PALETTES),
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_head),
    .pop           (pop),
    .palette_select(cfg.palette_select),
    .done          (done),
    .result        (result)
  );

endmodule

// ===== tb/tb.sv =====
module tb;
  import etpc_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int Settle     = 40;    // a little over the pixel latency

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  request_t   request = '0;
  logic       done;
  result_t    result;
  logic       cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  escape_time_palette_colorer dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state: register copies and palette contents
  logic [DenW-1:0]    lim   = ResetMaxIter;
  logic [DenW-1:0]    cyc   = ResetCycle;
  logic [CcW-1:0]     ncol  = ResetColors;
  logic [PalSelW-1:0] psel  = ResetPalette;
  logic [ColorW-1:0]  shade [Palettes*Entries];

  request_t requests_todo [$];
  result_t  colors_due [$];

  int  hold_off = 0;
  bit  bursty = 1'b0;
  int  cycles = 0;
  int  errors = 0;
  int  n_pixels = 0;
  int  n_black = 0;
  int  n_writes = 0;
  int  n_settings = 0;

  task automatic flag(string what, longint got, longint want);
    errors++;
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
  endtask

  function automatic logic [ChanW-1:0] blend(logic [ChanW-1:0] a, logic [ChanW-1:0] b,
                                             longint unsigned rem, longint unsigned den);
    return ChanW'((rem * b + (den - rem) * a) / den);
  endfunction

  // apply one taken request to the palette copy, or queue the color it must give
  function automatic void take_request(request_t r);
    result_t c;
    longint unsigned count, num, den, segs, scaled, k, rem;
    int unsigned cc, pal;
    logic [ColorW-1:0] lo, hi;
    if (op_t'(r.operation) == OP_WRITE) begin
      if (r.palette_number < Palettes && r.entry_index < Entries)
        shade[r.palette_number * Entries + r.entry_index] = r.entry_color;
      n_writes++;
      return;
    end
    count = r.iteration & CountMask;
    c = '0;
    if (count >= lim) begin
      c.escaped_limit = 1'b1;
      n_black++;
    end else begin
      if (cyc >= 2) begin
        den = cyc - 1;
        num = count % den;
      end else begin
        den = lim;
        num = count;
      end
      cc = ncol;
      if (cc < 2) cc = 2;
      if (cc > Entries) cc = Entries;
      segs = cc - 1;
      scaled = num * segs;
      k = scaled / den;
      rem = scaled % den;
      pal = psel % Palettes;
      lo = shade[pal * Entries + k];
      hi = shade[pal * Entries + k + 1];
      c.red   = blend(lo[23:16], hi[23:16], rem, den);
      c.green = blend(lo[15:8], hi[15:8], rem, den);
      c.blue  = blend(lo[7:0], hi[7:0], rem, den);
    end
    colors_due.push_back(c);
    n_pixels++;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      hold_off <= 0;
    end else begin
      if (start && !busy) take_request(request);
      if (!start || !busy) begin
        if (hold_off != 0) begin
          start <= 1'b0;
          hold_off <= hold_off - 1;
        end else if (requests_todo.size() != 0 && bursty && $urandom_range(0, 9) == 0) begin
          start <= 1'b0;
          hold_off <= $urandom_range(0, 15);
        end else if (requests_todo.size() != 0) begin
          request <= requests_todo.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (colors_due.size() == 0) begin
        flag("unexpected result", result, 0);
      end else begin
        want = colors_due.pop_front();
        if (result.red !== want.red) flag("red", result.red, want.red);
        if (result.green !== want.green) flag("green", result.green, want.green);
        if (result.blue !== want.blue) flag("blue", result.blue, want.blue);
        if (result.escaped_limit !== want.escaped_limit)
          flag("escaped_limit", result.escaped_limit, want.escaped_limit);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, colors_due.size());
      $display("Verification failed");
      $finish;
    end
  end

  function automatic request_t pixel(logic [IterW-1:0] it);
    request_t r;
    r.operation      = OP_COLOR;
    r.iteration      = it;
    r.palette_number = PalNumW'($urandom);
    r.entry_index    = EntIdxW'($urandom);
    r.entry_color    = ColorW'($urandom);
    return r;
  endfunction

  function automatic request_t palette_write(int p, int e, logic [ColorW-1:0] color);
    request_t r;
    r.operation      = OP_WRITE;
    r.iteration      = IterW'($urandom);
    r.palette_number = PalNumW'(p);
    r.entry_index    = EntIdxW'(e);
    r.entry_color    = color;
    return r;
  endfunction

  function automatic logic [IterW-1:0] pick_count();
    int roll;
    roll = $urandom_range(0, 9);
    if (lim != 0 && roll < 6) return IterW'($urandom_range(0, lim - 1));
    if (roll < 8) return IterW'(lim + $urandom_range(0, 2) - 1);
    return IterW'($urandom);
  endfunction

  function automatic request_t random_request();
    int roll;
    logic [ColorW-1:0] color;
    roll = $urandom_range(0, 19);
    if (roll < 3) begin
      color = (roll == 0) ? '0 : (roll == 1) ? '1 : ColorW'($urandom);
      return palette_write($urandom_range(0, Palettes - 1), $urandom_range(0, Entries - 1),
                           color);
    end
    return pixel(pick_count());
  endfunction

  // returns once nothing is in flight, writes included
  task automatic wait_drained();
    do @(posedge clk);
    while (requests_todo.size() != 0 || start || colors_due.size() != 0);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic set_reg(cfg_index_t idx, logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_MAX_ITER: lim = val;
      CFG_CYCLE:    cyc = val;
      CFG_COLORS:   ncol = val[CcW-1:0];
      CFG_PALETTE:  psel = val[PalSelW-1:0];
      default: ;
    endcase
  endtask

  // upper data bits above the narrow registers are random and must be dropped
  task automatic apply_setting(int mi, int cl, int cc, int sel);
    set_reg(CFG_MAX_ITER, CfgDataW'(mi));
    set_reg(CFG_CYCLE, CfgDataW'(cl));
    set_reg(CFG_COLORS, {(CfgDataW-CcW)'($urandom), CcW'(cc)});
    set_reg(CFG_PALETTE, {(CfgDataW-PalSelW)'($urandom), PalSelW'(sel)});
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  initial begin
    int fx_lim [6] = '{0, 1, 65535, 1000, 500, 65535};
    int fx_cyc [6] = '{0, 0, 0, 2, 65535, 1};
    int fx_cc  [6] = '{2, 0, 16, 1, 31, 17};
    int fx_sel [6] = '{1, 2, 3, 0, 1, 2};
    int fx_n   [6] = '{10, 10, 200, 150, 200, 200};
    int mi, cl, cc, sel, n;
    logic [ColorW-1:0] color;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every entry is loaded before any pixel can read it
    for (int p = 0; p < Palettes; p++) begin
      for (int e = 0; e < Entries; e++) begin
        color = ColorW'($urandom);
        if (p == 0 && e == 0) color = '0;
        if (p == 0 && e == 1) color = '1;
        if (p == 1 && e < 3) color = 24'h5a3cc3;   // equal neighbours
        if (p == 3 && e == Entries - 1) color = '1;
        requests_todo.push_back(palette_write(p, e, color));
      end
    end
    // reset settings: limit edges and a black-to-white gradient
    foreach (fx_lim[i]) begin end
    requests_todo.push_back(pixel(16'd0));
    requests_todo.push_back(pixel(16'd1));
    requests_todo.push_back(pixel(16'd128));
    requests_todo.push_back(pixel(16'd255));
    requests_todo.push_back(pixel(16'd256));
    requests_todo.push_back(pixel(16'd257));
    requests_todo.push_back(pixel(16'hffff));

    for (int ph = 0; ph < 11; ph++) begin
      wait_drained();
      if (ph < 6) begin
        mi = fx_lim[ph]; cl = fx_cyc[ph]; cc = fx_cc[ph]; sel = fx_sel[ph]; n = fx_n[ph];
        bursty = (ph % 2 == 0);
      end else begin
        mi = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 400) : $urandom_range(1, 65535);
        case ($urandom_range(0, 3))
          0: cl = $urandom_range(0, 1);
          1: cl = $urandom_range(2, 40);
          2: cl = $urandom_range(2, 600);
          default: cl = $urandom_range(0, 65535);
        endcase
        cc = $urandom_range(0, 31);
        sel = $urandom_range(0, 3);
        n = (ph == 10) ? 300 : 200;
        bursty = (ph != 10);
      end
      apply_setting(mi, cl, cc, sel);
      requests_todo.push_back(pixel(16'd0));
      requests_todo.push_back(pixel(IterW'(lim - 1)));
      requests_todo.push_back(pixel(lim));
      requests_todo.push_back(pixel(16'hffff));
      for (int i = 0; i < n; i++) requests_todo.push_back(random_request());
    end

    wait_drained();
    if (colors_due.size() != 0) flag("results never arrived", colors_due.size(), 0);
    $display("run covered %0d pixel requests (%0d drawn black at the limit)",
             n_pixels, n_black);
    $display("and %0d palette writes across %0d register settings", n_writes, n_settings + 1);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
